// ===== design/onsl_pkg.sv =====
// ----------------------------------------------------------------------------
// onsl_pkg
// Types, character codes and token kind mapping for the operator, number and
// string lexer.
// ----------------------------------------------------------------------------
package onsl_pkg;

  // Default width of the decimal accumulator
  localparam int unsigned DefValueBits = 32;

  // Result payload widths
  localparam int unsigned CharBits  = 8;
  localparam int unsigned KindBits  = 5;
  localparam int unsigned TokenBits = 32;

  // Character codes
  localparam logic [CharBits-1:0] CharEnd    = 8'd0;
  localparam logic [CharBits-1:0] CharQuote  = 8'h22;
  localparam logic [CharBits-1:0] CharPlus   = 8'h2B;
  localparam logic [CharBits-1:0] CharMinus  = 8'h2D;
  localparam logic [CharBits-1:0] CharStar   = 8'h2A;
  localparam logic [CharBits-1:0] CharSlash  = 8'h2F;
  localparam logic [CharBits-1:0] CharCaret  = 8'h5E;
  localparam logic [CharBits-1:0] CharEquals = 8'h3D;
  localparam logic [CharBits-1:0] CharDot    = 8'h2E;
  localparam logic [CharBits-1:0] CharZero   = 8'd48;
  localparam logic [CharBits-1:0] CharNine   = 8'd57;

  // Lexer mode
  typedef enum logic [3:0] {
    MODE_IDLE   = 4'd0,
    MODE_NUMBER = 4'd1,
    MODE_STRING = 4'd2,
    MODE_ADD    = 4'd3,
    MODE_SUB    = 4'd4,
    MODE_MUL    = 4'd5,
    MODE_DIV    = 4'd6,
    MODE_POW    = 4'd7,
    MODE_ASSIGN = 4'd8
  } mode_e;

  // Token kinds on the result stream
  typedef enum logic [KindBits-1:0] {
    KIND_NUMBER     = 5'd0,
    KIND_STR_CHAR   = 5'd1,
    KIND_STR_END    = 5'd2,
    KIND_ADD        = 5'd3,
    KIND_SUB        = 5'd4,
    KIND_MUL        = 5'd5,
    KIND_DIV        = 5'd6,
    KIND_POW        = 5'd7,
    KIND_INCR       = 5'd8,
    KIND_DECR       = 5'd9,
    KIND_ADD_ASSIGN = 5'd10,
    KIND_SUB_ASSIGN = 5'd11,
    KIND_MUL_ASSIGN = 5'd12,
    KIND_DIV_ASSIGN = 5'd13,
    KIND_POW_ASSIGN = 5'd14,
    KIND_ASSIGN     = 5'd15,
    KIND_EQUAL      = 5'd16
  } kind_e;

  function automatic logic is_digit(input logic [CharBits-1:0] c);
    return (c >= CharZero) && (c <= CharNine);
  endfunction

  // Mode entered when a byte is seen from idle
  function automatic mode_e start_mode(input logic [CharBits-1:0] c);
    mode_e m;
    m = MODE_IDLE;
    if (is_digit(c)) begin
      m = MODE_NUMBER;
    end else begin
      case (c)
        CharQuote:  m = MODE_STRING;
        CharPlus:   m = MODE_ADD;
        CharMinus:  m = MODE_SUB;
        CharStar:   m = MODE_MUL;
        CharSlash:  m = MODE_DIV;
        CharCaret:  m = MODE_POW;
        CharEquals: m = MODE_ASSIGN;
        default:    m = MODE_IDLE;
      endcase
    end
    return m;
  endfunction

  // Single operator token for a pending operator mode
  function automatic kind_e single_kind(input mode_e m);
    kind_e k;
    unique case (m)
      MODE_ADD: k = KIND_ADD;
      MODE_SUB: k = KIND_SUB;
      MODE_MUL: k = KIND_MUL;
      MODE_DIV: k = KIND_DIV;
      default:  k = KIND_POW;
    endcase
    return k;
  endfunction

  // Compound assignment token for a pending operator mode
  function automatic kind_e compound_kind(input mode_e m);
    kind_e k;
    unique case (m)
      MODE_ADD: k = KIND_ADD_ASSIGN;
      MODE_SUB: k = KIND_SUB_ASSIGN;
      MODE_MUL: k = KIND_MUL_ASSIGN;
      MODE_DIV: k = KIND_DIV_ASSIGN;
      default:  k = KIND_POW_ASSIGN;
    endcase
    return k;
  endfunction

endpackage

// ===== design/operator_number_string_lexer_unit.sv =====
// ----------------------------------------------------------------------------
// operator_number_string_lexer_unit
// Byte-stream lexer for numbers, quoted strings and arithmetic operators.
// ----------------------------------------------------------------------------
// Takes one text byte per cycle and returns at most one token per byte in
// the next cycle, through an output register. Input is accepted in every cycle
// in which the output register is empty or being taken downstream, so the
// sustained rate is one byte per clock; the only thing that holds input back
// is a stalled result. Decimal digits build a number (value wraps at
// VALUE_BITS, '.' inside a number is skipped) which is emitted on the first
// byte that ends it; that byte then starts a new token. A quoted string gives
// one token per character and an end token. Operators + - * / ^ = are emitted
// singly or as the compounds ++ -- += -= *= /= ^= ==. Byte 0 flushes any
// pending token and returns the lexer to idle. Other stray bytes are dropped.
module operator_number_string_lexer_unit #(
  parameter int unsigned VALUE_BITS = onsl_pkg::DefValueBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Text bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  // Tokens
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] token_value
  output logic [4:0]  m_axis_tuser    // [4:0] token_kind
);
  import onsl_pkg::*;

  localparam int unsigned WideBits = (VALUE_BITS > TokenBits) ? VALUE_BITS : TokenBits;

  mode_e                 mode_q, mode_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic [WideBits-1:0]   acc_wide;

  logic                  out_valid_q;
  kind_e                 out_kind_q;
  logic [TokenBits-1:0]  out_value_q;

  logic                  emit;
  kind_e                 kind;
  logic [TokenBits-1:0]  value;
  logic                  restart;
  logic                  s_fire;
  logic [CharBits-1:0]   c;
  logic [3:0]            digit;

  assign c        = s_axis_tdata;
  // '0'..'9' carry their value in the low nibble
  assign digit    = c[3:0];
  assign acc_wide = WideBits'(acc_q);
  assign s_fire   = s_axis_tvalid && s_axis_tready;

  // Accept a request whenever the result register is free or draining
  assign s_axis_tready = !out_valid_q || m_axis_tready;

  // Next mode, accumulator and token for the current byte
  always_comb begin
    mode_d  = mode_q;
    acc_d   = acc_q;
    emit    = 1'b0;
    kind    = KIND_NUMBER;
    value   = '0;
    restart = 1'b0;

    unique case (mode_q)
      MODE_NUMBER: begin
        if (is_digit(c)) begin
          acc_d = (acc_q << 3) + (acc_q << 1) + VALUE_BITS'(digit);
        end else if (c != CharDot) begin
          emit    = 1'b1;
          kind    = KIND_NUMBER;
          value   = acc_wide[TokenBits-1:0];
          acc_d   = '0;
          restart = 1'b1;
        end
      end
      MODE_STRING: begin
        emit = 1'b1;
        if (c == CharQuote || c == CharEnd) begin
          kind   = KIND_STR_END;
          mode_d = MODE_IDLE;
        end else begin
          kind  = KIND_STR_CHAR;
          value = TokenBits'(c);
        end
      end
      MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_POW: begin
        emit = 1'b1;
        if (c == CharEquals) begin
          kind   = compound_kind(mode_q);
          mode_d = MODE_IDLE;
        end else if (mode_q == MODE_ADD && c == CharPlus) begin
          kind   = KIND_INCR;
          mode_d = MODE_IDLE;
        end else if (mode_q == MODE_SUB && c == CharMinus) begin
          kind   = KIND_DECR;
          mode_d = MODE_IDLE;
        end else begin
          kind    = single_kind(mode_q);
          restart = 1'b1;
        end
      end
      MODE_ASSIGN: begin
        emit = 1'b1;
        if (c == CharEquals) begin
          kind   = KIND_EQUAL;
          mode_d = MODE_IDLE;
        end else begin
          kind    = KIND_ASSIGN;
          restart = 1'b1;
        end
      end
      default: begin
        restart = 1'b1;
      end
    endcase

    // Handle the ending byte afresh, as from idle
    if (restart) begin
      mode_d = start_mode(c);
      if (is_digit(c)) begin
        acc_d = VALUE_BITS'(digit);
      end
    end
  end

  // Advance lexer state on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      acc_q  <= '0;
    end else if (s_fire) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
    end
  end

  // Hold the token until downstream takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_fire) begin
      out_valid_q <= emit;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire && emit) begin
      out_kind_q  <= kind;
      out_value_q <= value;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_kind_q;

endmodule

// ===== tb/tb_operator_number_string_lexer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_operator_number_string_lexer_unit
// Self-checking bench for the operator, number and string lexer.
// ----------------------------------------------------------------------------
// A short directed script covers strings, the compounds ++ -- *= ^= ==,
// flushes on byte 0 and dropped enders. Token-shaped random text follows:
// numbers (some long enough to wrap, some holding dots), quoted strings,
// operators and noise. The text is sent under four idling phases. A tracker
// class mirrors the lexer state and compares every token taken from the
// result stream with the oldest predicted one.
module tb_operator_number_string_lexer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import onsl_pkg::*;

  localparam int unsigned ValueBits  = DefValueBits;
  localparam int unsigned StuckLimit = 2000;
  localparam int unsigned PhaseBytes = 470;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] value;
  } token_t;

  // Predicts the token stream and checks what the lexer returns
  class token_tracker;
    mode_e       mode;
    logic [63:0] acc;
    logic [63:0] acc_mask;
    token_t      tokens_due[$];
    int unsigned mismatches;

    function new();
      mode       = MODE_IDLE;
      acc        = '0;
      acc_mask   = (ValueBits >= 64) ? '1 : ((64'd1 << ValueBits) - 64'd1);
      mismatches = 0;
    endfunction

    // Treat a byte as if the lexer were idle
    function void enter_token(logic [7:0] c);
      mode = MODE_IDLE;
      if (c >= CharZero && c <= CharNine) begin
        acc  = 64'(c - CharZero) & acc_mask;
        mode = MODE_NUMBER;
      end else begin
        case (c)
          CharQuote:  mode = MODE_STRING;
          CharPlus:   mode = MODE_ADD;
          CharMinus:  mode = MODE_SUB;
          CharStar:   mode = MODE_MUL;
          CharSlash:  mode = MODE_DIV;
          CharCaret:  mode = MODE_POW;
          CharEquals: mode = MODE_ASSIGN;
          default:    mode = MODE_IDLE;
        endcase
      end
    endfunction

    // Advance the lexer state by one accepted byte
    function void note_byte(logic [7:0] c);
      token_t tok;
      bit     emits;
      emits     = 1'b0;
      tok.kind  = KIND_NUMBER;
      tok.value = '0;
      case (mode)
        MODE_NUMBER: begin
          if (c >= CharZero && c <= CharNine) begin
            acc = (acc * 64'd10 + 64'(c - CharZero)) & acc_mask;
          end else if (c != CharDot) begin
            emits     = 1'b1;
            tok.value = acc[31:0];
            acc       = '0;
            enter_token(c);
          end
        end
        MODE_STRING: begin
          emits = 1'b1;
          if (c == CharQuote || c == CharEnd) begin
            tok.kind = KIND_STR_END;
            mode     = MODE_IDLE;
          end else begin
            tok.kind  = KIND_STR_CHAR;
            tok.value = {24'd0, c};
          end
        end
        MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_POW: begin
          emits = 1'b1;
          if (c == CharEquals) begin
            case (mode)
              MODE_ADD: tok.kind = KIND_ADD_ASSIGN;
              MODE_SUB: tok.kind = KIND_SUB_ASSIGN;
              MODE_MUL: tok.kind = KIND_MUL_ASSIGN;
              MODE_DIV: tok.kind = KIND_DIV_ASSIGN;
              default:  tok.kind = KIND_POW_ASSIGN;
            endcase
            mode = MODE_IDLE;
          end else if (mode == MODE_ADD && c == CharPlus) begin
            tok.kind = KIND_INCR;
            mode     = MODE_IDLE;
          end else if (mode == MODE_SUB && c == CharMinus) begin
            tok.kind = KIND_DECR;
            mode     = MODE_IDLE;
          end else begin
            case (mode)
              MODE_ADD: tok.kind = KIND_ADD;
              MODE_SUB: tok.kind = KIND_SUB;
              MODE_MUL: tok.kind = KIND_MUL;
              MODE_DIV: tok.kind = KIND_DIV;
              default:  tok.kind = KIND_POW;
            endcase
            enter_token(c);
          end
        end
        MODE_ASSIGN: begin
          emits = 1'b1;
          if (c == CharEquals) begin
            tok.kind = KIND_EQUAL;
            mode     = MODE_IDLE;
          end else begin
            tok.kind = KIND_ASSIGN;
            enter_token(c);
          end
        end
        default: enter_token(c);
      endcase
      if (emits) tokens_due.push_back(tok);
    endfunction

    // Compare one returned token with the oldest prediction
    function void check_token(logic [4:0] kind_bits, logic [31:0] data);
      token_t tok;
      if (tokens_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: unexpected token kind %0d value %h", $realtime, kind_bits, data);
        return;
      end
      tok = tokens_due.pop_front();
      if (kind_bits != tok.kind || data != tok.value) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: token mismatch: expected kind %0d value %h, got kind %0d value %h",
                   $realtime, tok.kind, tok.value, kind_bits, data);
      end
    endfunction

    function int unsigned pending();
      return tokens_due.size();
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [4:0]  m_axis_tuser;

  int unsigned  send_idle_pct  = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  stuck_cycles   = 0;
  token_tracker tracker        = new();
  logic [7:0]   text_q[$];

  localparam logic [7:0] OpChars [6] = '{CharPlus, CharMinus, CharStar, CharSlash,
                                         CharCaret, CharEquals};

  // Strings, the compounds ++ -- *= ^= ==, flushes on byte 0 and enders that start nothing
  localparam logic [7:0] DirText [26] = '{
    CharQuote, 8'hFF, 8'h01, CharQuote, CharPlus, CharPlus, CharMinus, CharMinus,
    CharStar, CharEquals, CharSlash, CharCaret, CharEquals, CharEquals, CharEquals,
    CharZero, CharDot, "2", CharEnd, CharEquals, "x", CharNine, "a", CharEnd,
    CharQuote, CharEnd
  };

  operator_number_string_lexer_unit #(
    .VALUE_BITS(ValueBits)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Stall the token stream at the phase rate
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check tokens before noting this edge's byte, which cannot affect them
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) tracker.check_token(m_axis_tuser, m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) tracker.note_byte(s_axis_tdata);
    end
  end

  // End the run if nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= StuckLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  // Offer one byte, idling at the phase rate first, and hold until taken
  task automatic send_text_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Hold the text back until every predicted token has come out
  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  // Queue the bytes of one random token or separator
  function automatic void add_random_token();
    int unsigned pick;
    int unsigned len;
    logic [7:0]  ch;
    pick = $urandom_range(99);
    if (pick < 30) begin
      // Mostly short numbers, a few long enough to wrap, some with dots
      len = ($urandom_range(9) == 0) ? $urandom_range(24, 10) : $urandom_range(6, 1);
      for (int unsigned i = 0; i < len; i++) begin
        text_q.push_back(CharZero + 8'($urandom_range(9)));
        if (i + 1 < len && $urandom_range(19) == 0) text_q.push_back(CharDot);
      end
    end else if (pick < 45) begin
      text_q.push_back(CharQuote);
      len = $urandom_range(10);
      for (int unsigned i = 0; i < len; i++) begin
        ch = 8'($urandom_range(255, 1));
        text_q.push_back((ch == CharQuote) ? ch + 8'd1 : ch);
      end
      text_q.push_back(($urandom_range(9) == 0) ? CharEnd : CharQuote);
    end else if (pick < 80) begin
      ch = OpChars[$urandom_range(5)];
      text_q.push_back(ch);
      len = $urandom_range(9);
      if (len < 4) text_q.push_back(CharEquals);
      else if (len < 6) text_q.push_back(ch);
    end else if (pick < 88) begin
      text_q.push_back(CharEnd);
    end else if (pick < 96) begin
      case ($urandom_range(2))
        0:       text_q.push_back(" ");
        1:       text_q.push_back(8'h0A);
        default: text_q.push_back(CharDot);
      endcase
    end else begin
      text_q.push_back(8'($urandom_range(255)));
    end
  endfunction

  // Send one phase of random text under the given idling rates
  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    int unsigned sent;
    sent           = 0;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (sent < PhaseBytes) begin
      add_random_token();
      while (text_q.size() != 0) begin
        send_text_byte(text_q.pop_front());
        sent++;
      end
    end
    hold_until_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirText[i]) send_text_byte(DirText[i]);
    hold_until_drained();

    run_phase(0, 0);
    run_phase(72, 0);
    run_phase(0, 72);
    run_phase(19, 19);

    // Flush whatever token the last phase left pending
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_text_byte(CharEnd);
    hold_until_drained();
    repeat (8) @(posedge clk_i);

    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
